@@ src/cbpd_pkg.sv @@
// cbpd_pkg: shared codes, stage word types and helper functions for the cursor bitmap
// pixel decoder; used by the top level and its checker, depends on nothing else
package cbpd_pkg;

   // item kinds carried on req_tuser
   localparam logic [1:0] MODE_PALETTE = 2'd0;
   localparam logic [1:0] MODE_COLOUR  = 2'd1;
   localparam logic [1:0] MODE_MASK    = 2'd2;
   localparam logic [1:0] MODE_READ    = 2'd3;

   // pixel depth codes
   localparam logic [2:0] DEPTH_1BPP  = 3'd0;
   localparam logic [2:0] DEPTH_2BPP  = 3'd1;
   localparam logic [2:0] DEPTH_4BPP  = 3'd2;
   localparam logic [2:0] DEPTH_8BPP  = 3'd3;
   localparam logic [2:0] DEPTH_16BPP = 3'd4;
   localparam logic [2:0] DEPTH_32BPP = 3'd5;

   // register indexes on the csr port
   localparam logic [1:0] REG_DEPTH_CODE = 2'd0;
   localparam logic [1:0] REG_WIDTH      = 2'd1;
   localparam logic [1:0] REG_HEIGHT     = 2'd2;

   localparam int CSR_AW     = 4;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;
   localparam int CALC_W     = 16;   // byte address arithmetic width

   localparam logic [2:0] RESET_DEPTH_CODE = DEPTH_8BPP;
   localparam logic [5:0] RESET_WIDTH      = 6'd32;
   localparam logic [5:0] RESET_HEIGHT     = 6'd32;
   localparam logic [8:0] PALETTE_DEPTH    = 9'd256;

   // stage 1: accepted word plus flipped row
   typedef struct packed {
      logic [1:0]  mode;
      logic [11:0] load_address;
      logic [7:0]  load_byte;
      logic [23:0] entry_rgb;
      logic [4:0]  x;
      logic [5:0]  row;
      logic        oor;
   } s1_type;

   // stage 2: store data arrives from the colour and mask memories
   typedef struct packed {
      logic        mode_read;
      logic        pal_write;
      logic [7:0]  pal_addr;
      logic [23:0] entry_rgb;
      logic        oor;
      logic [2:0]  code;
      logic [1:0]  lane;
      logic [2:0]  shift;
      logic        colour_oob;
      logic        mask_apply;
      logic [2:0]  mask_sel;
   } s2_type;

   // stage 3: palette data arrives, direct colours already formed
   typedef struct packed {
      logic       oor;
      logic       use_pal;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       mask_clear;
   } s3_type;

   // row pitch in bytes, padded to 32 bits
   function automatic logic [7:0] pitch_bytes(input logic [2:0] code, input logic [5:0] width);
      logic [13:0] bits;
      logic [13:0] words;
      bits  = {8'd0, width} << code;
      words = (bits + 14'd31) >> 5;
      return {words[5:0], 2'b00};
   endfunction

   // palette index mask for 1, 2, 4 and 8 bit pixels
   function automatic logic [7:0] index_mask(input logic [2:0] code);
      logic [7:0] m;
      case (code)
         DEPTH_1BPP: m = 8'h01;
         DEPTH_2BPP: m = 8'h03;
         DEPTH_4BPP: m = 8'h0f;
         default:    m = 8'hff;
      endcase
      return m;
   endfunction

endpackage

@@ src/cbpd_ram.sv @@
// cbpd_ram: generic single write port, single read port memory with registered read
// depends on nothing
module cbpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/cursor_bitmap_pixel_decoder.sv @@
// cursor_bitmap_pixel_decoder: four-stage pixel unpack pipeline with palette and and-mask
// depends on cbpd_pkg and cbpd_ram
// a read word passes stages 1 to 3 and the output register; load words give none on rsp
// throughput: one word per cycle unless rsp stalls; each store has a single read port
// each word reads a 32-bit colour row of four byte banks and a mask byte, then the palette
// reset: synchronous, clears all valid bits and returns the registers to 8 bpp, 32 x 32
// reset leaves store contents untouched; entries read before being written are undefined
module cursor_bitmap_pixel_decoder
   import cbpd_pkg::*;
#(
   parameter int MAX_WIDTH  = 32,
   parameter int MAX_HEIGHT = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: load_address[11:0], load_byte[19:12], entry_blue[27:20], entry_green[35:28],
   //        entry_red[43:36], pixel_x[48:44], pixel_y[53:49], zero pad[55:54]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: mode[1:0]
   input  logic [1:0]            req_tuser,
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // tuser: out_of_range[0]
   output logic                  rsp_tuser,
   // csr port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_AW-1:0]     csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // store geometry follows from the largest image
   localparam int COLOUR_WORDS = MAX_WIDTH * MAX_HEIGHT;
   localparam int COLOUR_DEPTH = 4 * COLOUR_WORDS;
   localparam int MASK_DEPTH   = ((MAX_WIDTH + 31) / 32) * 4 * MAX_HEIGHT;
   localparam int CAW          = $clog2(COLOUR_WORDS);
   localparam int MAW          = $clog2(MASK_DEPTH);

   // ---------------------------------------------------------------- registers
   logic [2:0] depth_code_ff;
   logic [5:0] width_ff;
   logic [5:0] height_ff;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_code_ff <= RESET_DEPTH_CODE;
         width_ff      <= RESET_WIDTH;
         height_ff     <= RESET_HEIGHT;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_DEPTH_CODE: depth_code_ff <= csr_pwdata[2:0];
            REG_WIDTH:      width_ff      <= csr_pwdata[5:0];
            REG_HEIGHT:     height_ff     <= csr_pwdata[5:0];
            default: begin
               // writes past the register list are dropped
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_DEPTH_CODE: csr_prdata = {29'd0, depth_code_ff};
         REG_WIDTH:      csr_prdata = {26'd0, width_ff};
         REG_HEIGHT:     csr_prdata = {26'd0, height_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- stage flow
   // each stage loads when it is empty or its successor moves, so bubbles collapse
   logic   s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic   s1_ready, s2_ready, s3_ready, out_ready;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                  out_oor_ff, out_oor_in;

   assign out_ready  = ~out_valid_ff | rsp_tready;
   assign s3_ready   = ~s3_valid_ff | out_ready;
   assign s2_ready   = ~s2_valid_ff | s3_ready;
   assign s1_ready   = ~s1_valid_ff | s2_ready;
   assign req_tready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         // load words leave the pipe once the palette write is done
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff & s2_ff.mode_read;
         end
         if (out_ready) begin
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
      if (s3_ready) begin
         s3_ff <= s3_in;
      end
      if (out_ready) begin
         out_data_ff <= out_data_in;
         out_oor_ff  <= out_oor_in;
      end
   end

   // ---------------------------------------------------------------- stage 1 in
   // unpack the word, range check and vertical flip
   logic [4:0] req_x;
   logic [4:0] req_y;

   assign req_x = req_tdata[48:44];
   assign req_y = req_tdata[53:49];

   always_comb begin
      s1_in.mode         = req_tuser;
      s1_in.load_address = req_tdata[11:0];
      s1_in.load_byte    = req_tdata[19:12];
      s1_in.entry_rgb    = {req_tdata[43:36], req_tdata[35:28], req_tdata[27:20]};
      s1_in.x            = req_x;
      s1_in.oor          = ({1'b0, req_x} >= width_ff) || ({1'b0, req_y} >= height_ff);
      s1_in.row          = height_ff - 6'd1 - {1'b0, req_y};
   end

   // ---------------------------------------------------------------- stage 1 work
   // byte addresses for the colour and mask stores, plus the sub-byte shift
   logic [7:0]        pitch;
   logic [13:0]       row_base;
   logic [11:0]       bit_pos;
   logic [CALC_W-1:0] colour_addr;
   logic [CALC_W-1:0] colour_word;
   logic [3:0]        mask_pitch;
   logic [6:0]        width_round;
   logic [9:0]        mask_row_base;
   logic [CALC_W-1:0] mask_addr;
   logic [3:0]        sub_shift;
   logic [CALC_W-1:0] load_addr_ext;
   logic [CALC_W-1:0] load_word;
   logic              colour_oob;
   logic              mask_oob;
   logic              colour_we;
   logic              mask_we;

   always_comb begin
      pitch         = pitch_bytes(depth_code_ff, width_ff);
      row_base      = {8'd0, s1_ff.row} * {6'd0, pitch};
      bit_pos       = {7'd0, s1_ff.x} << depth_code_ff;
      colour_addr   = CALC_W'(row_base) + CALC_W'(bit_pos[11:3]);
      colour_word   = colour_addr >> 2;
      colour_oob    = 32'(colour_addr) >= COLOUR_DEPTH;
      // msb-first packing: first pixel sits in the top bits of its byte
      sub_shift     = 4'd8 - (4'd1 << depth_code_ff[1:0]) - {1'b0, bit_pos[2:0]};

      width_round   = {1'b0, width_ff} + 7'd31;
      mask_pitch    = {width_round[6:5], 2'b00};
      mask_row_base = {4'd0, s1_ff.row} * {6'd0, mask_pitch};
      mask_addr     = CALC_W'(mask_row_base) + CALC_W'(s1_ff.x[4:3]);
      mask_oob      = 32'(mask_addr) >= MASK_DEPTH;

      load_addr_ext = CALC_W'(s1_ff.load_address);
      load_word     = load_addr_ext >> 2;
      colour_we     = s1_valid_ff && s2_ready && (s1_ff.mode == MODE_COLOUR)
                      && (32'(load_addr_ext) < COLOUR_DEPTH);
      mask_we       = s1_valid_ff && s2_ready && (s1_ff.mode == MODE_MASK)
                      && (32'(load_addr_ext) < MASK_DEPTH);

      s2_in.mode_read  = s1_ff.mode == MODE_READ;
      s2_in.pal_write  = (s1_ff.mode == MODE_PALETTE)
                         && ({1'b0, s1_ff.load_address} < {4'd0, PALETTE_DEPTH});
      s2_in.pal_addr   = s1_ff.load_address[7:0];
      s2_in.entry_rgb  = s1_ff.entry_rgb;
      s2_in.oor        = s1_ff.oor;
      s2_in.code       = depth_code_ff;
      s2_in.lane       = colour_addr[1:0];
      s2_in.shift      = sub_shift[2:0];
      s2_in.colour_oob = colour_oob;
      // and-mask covers only whole bytes of columns
      s2_in.mask_apply = (s1_ff.x[4:3] < width_ff[5:3]) & ~mask_oob;
      s2_in.mask_sel   = 3'd7 - s1_ff.x[2:0];
   end

   // colour store: four byte banks, one 32-bit row word read per item
   logic [31:0] colour_data;
   logic [7:0]  mask_data;

   for (genvar lane = 0; lane < 4; lane++) begin : g_colour_bank
      cbpd_ram #(
         .WIDTH (8),
         .DEPTH (COLOUR_WORDS)
      ) u_colour_bank (
         .clock   (clock),
         .wr_en   (colour_we && (s1_ff.load_address[1:0] == 2'(lane))),
         .wr_addr (load_word[CAW-1:0]),
         .wr_data (s1_ff.load_byte),
         .rd_en   (s2_ready),
         .rd_addr (colour_word[CAW-1:0]),
         .rd_data (colour_data[lane*8 +: 8])
      );
   end

   cbpd_ram #(
      .WIDTH (8),
      .DEPTH (MASK_DEPTH)
   ) u_mask_store (
      .clock   (clock),
      .wr_en   (mask_we),
      .wr_addr (load_addr_ext[MAW-1:0]),
      .wr_data (s1_ff.load_byte),
      .rd_en   (s2_ready),
      .rd_addr (mask_addr[MAW-1:0]),
      .rd_data (mask_data)
   );

   // ---------------------------------------------------------------- stage 2 work
   // pick bytes out of the row word, form the palette index and direct colours
   logic [31:0] row_word;
   logic [7:0]  lane_byte;
   logic [7:0]  pal_index;
   logic [7:0]  hi_byte;
   logic [7:0]  lo_byte;
   logic [15:0] px16;
   logic        pal_we;

   always_comb begin
      // bytes past the store read as zero
      row_word  = s2_ff.colour_oob ? 32'd0 : colour_data;
      lane_byte = row_word[s2_ff.lane*8 +: 8];
      pal_index = (lane_byte >> s2_ff.shift) & index_mask(s2_ff.code);
      // x555 word is first byte high, second byte low
      hi_byte   = s2_ff.lane[1] ? row_word[23:16] : row_word[7:0];
      lo_byte   = s2_ff.lane[1] ? row_word[31:24] : row_word[15:8];
      px16      = {hi_byte, lo_byte};
      pal_we    = s2_valid_ff & s3_ready & s2_ff.pal_write;

      s3_in.oor        = s2_ff.oor;
      s3_in.mask_clear = s2_ff.mask_apply & mask_data[s2_ff.mask_sel];
      s3_in.use_pal    = 1'b0;
      s3_in.red        = 8'd0;
      s3_in.green      = 8'd0;
      s3_in.blue       = 8'd0;
      s3_in.alpha      = 8'd0;
      case (s2_ff.code) inside
         DEPTH_1BPP, DEPTH_2BPP, DEPTH_4BPP, DEPTH_8BPP: begin
            s3_in.use_pal = 1'b1;
         end
         DEPTH_16BPP: begin
            s3_in.red   = {px16[14:10], 3'b000};
            s3_in.green = {px16[9:5], 3'b000};
            s3_in.blue  = {px16[4:0], 3'b000};
            s3_in.alpha = 8'hff;
         end
         DEPTH_32BPP: begin
            s3_in.blue  = row_word[7:0];
            s3_in.green = row_word[15:8];
            s3_in.red   = row_word[23:16];
            s3_in.alpha = row_word[31:24];
         end
         default: begin
            // unused depth codes give a transparent black pixel
         end
      endcase
   end

   // palette: red, green, blue from high to low bits
   logic [23:0] pal_data;

   cbpd_ram #(
      .WIDTH (24),
      .DEPTH (256)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (s2_ff.pal_addr),
      .wr_data (s2_ff.entry_rgb),
      .rd_en   (s3_ready),
      .rd_addr (pal_index),
      .rd_data (pal_data)
   );

   // ---------------------------------------------------------------- stage 3 work
   // final colour select, mask and range flag
   logic [7:0] red, green, blue, alpha;

   always_comb begin
      if (s3_ff.use_pal) begin
         red   = pal_data[23:16];
         green = pal_data[15:8];
         blue  = pal_data[7:0];
         alpha = 8'hff;
      end else begin
         red   = s3_ff.red;
         green = s3_ff.green;
         blue  = s3_ff.blue;
         alpha = s3_ff.alpha;
      end
      if (s3_ff.mask_clear) begin
         alpha = 8'd0;
      end
      if (s3_ff.oor) begin
         out_data_in = 32'd0;
      end else begin
         out_data_in = {alpha, blue, green, red};
      end
      out_oor_in = s3_ff.oor;
   end

   // ---------------------------------------------------------------- response
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_oor_ff;

endmodule

@@ src/cbpd_checker.sv @@
// cbpd_checker: port-level assertions for the cursor bitmap pixel decoder
// depends on cbpd_pkg; bound to the top level at the end of this file
module cbpd_checker
   import cbpd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // reset empties the pipe
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word present after reset");

   // out-of-range pixels carry no colour
   a_oor_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("out-of-range pixel with nonzero colour");

   // an empty output stage means every stage can take a word
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled while output stage is empty");

   // a stalled result is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result word changed");

endmodule

bind cursor_bitmap_pixel_decoder cbpd_checker u_cbpd_checker (.*);

@@ tb/cbpd_tb_pkg.sv @@
// cbpd_tb_pkg: word types and the pixel tracker class for the pixel decoder testbench
// the tracker mirrors the palette, colour and mask stores and predicts each pixel read
// depends on cbpd_pkg
package cbpd_tb_pkg;
   import cbpd_pkg::*;

   localparam int unsigned COLOUR_BYTES = 4096;   // 32 columns x 4 bytes x 32 rows
   localparam int unsigned MASK_BYTES   = 128;    // one 32-bit mask word per row

   // depth codes with no pixel format behind them
   localparam logic [2:0] DEPTH_UNUSED_6 = 3'd6;
   localparam logic [2:0] DEPTH_UNUSED_7 = 3'd7;

   typedef struct packed {
      logic [1:0]  mode;
      logic [11:0] load_address;
      logic [7:0]  load_byte;
      logic [7:0]  entry_blue;
      logic [7:0]  entry_green;
      logic [7:0]  entry_red;
      logic [4:0]  pixel_x;
      logic [4:0]  pixel_y;
   } req_word_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       oor;
   } pixel_type;

   class pixel_tracker;
      logic [23:0] palette_rgb [256];
      bit          palette_set [256];
      logic [7:0]  colour_mem [COLOUR_BYTES];
      bit          colour_set [COLOUR_BYTES];
      logic [7:0]  mask_mem [MASK_BYTES];
      bit          mask_set [MASK_BYTES];
      logic [2:0]  depth_code;
      logic [5:0]  img_width;
      logic [5:0]  img_height;
      pixel_type   pending_pixels [$];
      int          mismatches;

      function new();
         depth_code = RESET_DEPTH_CODE;
         img_width  = RESET_WIDTH;
         img_height = RESET_HEIGHT;
         mismatches = 0;
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%t mismatch on %s: expected %h, got %h", $realtime, name, want, got);
         end
      endfunction

      function bit in_image(logic [4:0] x, logic [4:0] y);
         return ({1'b0, x} < img_width) && ({1'b0, y} < img_height);
      endfunction

      // bitmap rows are stored bottom up
      function int unsigned stored_row(logic [4:0] y);
         return 32'(img_height) - 32'(y) - 1;
      endfunction

      // first colour byte of a pixel, rows padded to 32 bits
      function int unsigned colour_addr(logic [4:0] x, logic [4:0] y);
         int unsigned bpp;
         int unsigned pitch;
         bpp   = 1 << depth_code;
         pitch = ((bpp * img_width + 31) / 32) * 4;
         return stored_row(y) * pitch + (x * bpp) / 8;
      endfunction

      function logic [7:0] colour_read(int unsigned a);
         return (a < COLOUR_BYTES) ? colour_mem[a] : 8'h00;
      endfunction

      // msb-first palette index for 1, 2, 4 and 8 bit pixels
      function logic [7:0] pal_index(logic [4:0] x, logic [4:0] y);
         int unsigned bpp;
         int unsigned sh;
         logic [7:0]  b;
         bpp = 1 << depth_code;
         b   = colour_read(colour_addr(x, y));
         sh  = 8 - bpp - ((x * bpp) % 8);
         return 8'((b >> sh) & ((1 << bpp) - 1));
      endfunction

      // the and-mask only covers whole bytes of columns
      function bit mask_applies(logic [4:0] x);
         return 32'(x) < (32'(img_width) / 8) * 8;
      endfunction

      function int unsigned mask_addr(logic [4:0] x, logic [4:0] y);
         return stored_row(y) * (((img_width + 31) / 32) * 4) + x / 8;
      endfunction

      function pixel_type decode_pixel(logic [4:0] x, logic [4:0] y);
         pixel_type   p;
         int unsigned a;
         int unsigned ma;
         logic [15:0] v;
         logic [23:0] e;
         logic [7:0]  mb;
         p = '0;
         if (!in_image(x, y)) begin
            p.oor = 1'b1;
            return p;
         end
         a = colour_addr(x, y);
         if (depth_code <= DEPTH_8BPP) begin
            e       = palette_rgb[pal_index(x, y)];
            p.red   = e[23:16];
            p.green = e[15:8];
            p.blue  = e[7:0];
            p.alpha = 8'hff;
         end else if (depth_code == DEPTH_16BPP) begin
            // first byte is the high byte of the x555 word
            v       = {colour_read(a), colour_read(a + 1)};
            p.blue  = {v[4:0], 3'b000};
            p.green = {v[9:5], 3'b000};
            p.red   = {v[14:10], 3'b000};
            p.alpha = 8'hff;
         end else if (depth_code == DEPTH_32BPP) begin
            p.blue  = colour_read(a);
            p.green = colour_read(a + 1);
            p.red   = colour_read(a + 2);
            p.alpha = colour_read(a + 3);
         end
         if (mask_applies(x)) begin
            ma = mask_addr(x, y);
            mb = (ma < MASK_BYTES) ? mask_mem[ma] : 8'h00;
            if (mb[3'd7 - x[2:0]])
               p.alpha = 8'h00;
         end
         return p;
      endfunction

      // names one store entry that a read of (x, y) would use before it was written
      function bit find_unwritten(logic [4:0] x, logic [4:0] y,
                                  output logic [1:0] mode, output logic [11:0] addr);
         int unsigned a;
         int unsigned n;
         int unsigned ma;
         logic [7:0]  idx;
         mode = MODE_READ;
         addr = '0;
         if (!in_image(x, y))
            return 0;
         if (depth_code <= DEPTH_32BPP) begin
            a = colour_addr(x, y);
            n = (depth_code <= DEPTH_8BPP) ? 1 : (1 << (depth_code - DEPTH_8BPP));
            for (int i = 0; i < n; i++) begin
               if (a + i < COLOUR_BYTES && !colour_set[a + i]) begin
                  mode = MODE_COLOUR;
                  addr = 12'(a + i);
                  return 1;
               end
            end
            if (depth_code <= DEPTH_8BPP) begin
               idx = pal_index(x, y);
               if (!palette_set[idx]) begin
                  mode = MODE_PALETTE;
                  addr = {4'd0, idx};
                  return 1;
               end
            end
         end
         if (mask_applies(x)) begin
            ma = mask_addr(x, y);
            if (ma < MASK_BYTES && !mask_set[ma]) begin
               mode = MODE_MASK;
               addr = 12'(ma);
               return 1;
            end
         end
         return 0;
      endfunction

      function void note_word(req_word_type w);
         case (w.mode)
            MODE_PALETTE: begin
               if (w.load_address < PALETTE_DEPTH) begin
                  palette_rgb[w.load_address[7:0]] = {w.entry_red, w.entry_green, w.entry_blue};
                  palette_set[w.load_address[7:0]] = 1'b1;
               end
            end
            MODE_COLOUR: begin
               if (w.load_address < COLOUR_BYTES) begin
                  colour_mem[w.load_address] = w.load_byte;
                  colour_set[w.load_address] = 1'b1;
               end
            end
            MODE_MASK: begin
               if (w.load_address < MASK_BYTES) begin
                  mask_mem[w.load_address] = w.load_byte;
                  mask_set[w.load_address] = 1'b1;
               end
            end
            default: begin
               pending_pixels.push_back(decode_pixel(w.pixel_x, w.pixel_y));
            end
         endcase
      endfunction

      function void check_pixel(logic [31:0] data, logic oor);
         pixel_type want;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%t pixel %h with no read outstanding", $realtime, data);
            return;
         end
         want = pending_pixels.pop_front();
         compare_field("red", want.red, data[7:0]);
         compare_field("green", want.green, data[15:8]);
         compare_field("blue", want.blue, data[23:16]);
         compare_field("alpha", want.alpha, data[31:24]);
         compare_field("out_of_range", want.oor, oor);
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_DEPTH_CODE: depth_code = value[2:0];
            REG_WIDTH:      img_width  = value[5:0];
            REG_HEIGHT:     img_height = value[5:0];
            default: ;
         endcase
      endfunction

      function void check_reg(logic [1:0] idx, logic [31:0] rd);
         case (idx)
            REG_DEPTH_CODE: compare_field("depth code readback", 32'(depth_code), 32'(rd[2:0]));
            REG_WIDTH:      compare_field("width readback", 32'(img_width), 32'(rd[5:0]));
            REG_HEIGHT:     compare_field("height readback", 32'(img_height), 32'(rd[5:0]));
            default: ;
         endcase
      endfunction
   endclass

endpackage

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for cursor_bitmap_pixel_decoder, stream and csr stimulus
// with random idling on both sides, predicted pixels checked in order
// depends on cbpd_pkg, cbpd_tb_pkg and the decoder rtl
module tb_top;
   import cbpd_pkg::*;
   import cbpd_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEMS        = 950;      // words to send before the run winds down
   localparam int QUIET_ITEMS  = 120;      // last stretch runs with no idling
   localparam int PHASE_ITEMS  = 80;       // words per random configuration
   localparam int DRAIN_CYCLES = 8;        // covers the pipe stages for trailing loads
   localparam int HOLD_CYCLES  = 200;      // long receiver back-pressure
   localparam int LIMIT        = 400000;   // watchdog in clock cycles

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // tdata: load_address, load_byte, entry_blue, entry_green, entry_red, pixel_x, pixel_y, pad
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // tuser: mode
   logic [1:0]            req_tuser = MODE_PALETTE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // tdata: out_red, out_green, out_blue, out_alpha
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // tuser: out_of_range
   logic                  rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]     csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   pixel_tracker tracker;
   bit           idle_on = 1'b1;   // random bursts of idling on both sides
   bit           hold_rsp = 1'b0;  // asks the receiver for one long hold-off
   int           words = 0;        // accepted request words
   int           cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   cursor_bitmap_pixel_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // every accepted pixel is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_pixel(rsp_tdata, rsp_tuser);
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int stall;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready = 1'b0;
            stall = $urandom_range(1, 8);
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   function automatic req_word_type random_word();
      req_word_type w;
      w.mode         = 2'($urandom_range(0, 2));
      w.load_address = 12'($urandom);
      w.load_byte    = 8'($urandom);
      w.entry_blue   = 8'($urandom);
      w.entry_green  = 8'($urandom);
      w.entry_red    = 8'($urandom);
      w.pixel_x      = 5'($urandom);
      w.pixel_y      = 5'($urandom);
      return w;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_word(req_word_type w);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(negedge clock);
      end
      req_tuser  = w.mode;
      req_tdata  = {2'b00, w.pixel_y, w.pixel_x, w.entry_red, w.entry_green, w.entry_blue,
                    w.load_byte, w.load_address};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      tracker.note_word(w);
      words++;
      @(negedge clock);
   endtask

   task automatic send_load(logic [1:0] mode, logic [11:0] addr, logic [7:0] value,
                            logic [23:0] rgb);
      req_word_type w;
      w = random_word();
      w.mode         = mode;
      w.load_address = addr;
      w.load_byte    = value;
      {w.entry_red, w.entry_green, w.entry_blue} = rgb;
      send_word(w);
   endtask

   // fills whatever the pixel needs that was never written, then reads it
   task automatic read_pixel(logic [4:0] x, logic [4:0] y);
      req_word_type w;
      logic [1:0]   m;
      logic [11:0]  a;
      while (tracker.find_unwritten(x, y, m, a))
         send_load(m, a, 8'($urandom), 24'($urandom));
      w = random_word();
      w.mode    = MODE_READ;
      w.pixel_x = x;
      w.pixel_y = y;
      send_word(w);
   endtask

   // sender pauses until every predicted pixel came back and trailing loads retired
   task automatic drain();
      req_tvalid = 1'b0;
      while (tracker.pending_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // apb write followed by a read back of the same register
   task automatic program_reg(logic [1:0] idx, logic [31:0] value);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_reg(idx, value);
      @(negedge clock);
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.check_reg(idx, csr_prdata);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_config(logic [2:0] code, logic [5:0] width, logic [5:0] height);
      drain();
      program_reg(REG_DEPTH_CODE, {29'd0, code});
      program_reg(REG_WIDTH, {26'd0, width});
      program_reg(REG_HEIGHT, {26'd0, height});
   endtask

   // mostly reads inside the image, some anywhere, the rest stray loads
   task automatic random_item();
      int           r;
      int           xmax;
      int           ymax;
      req_word_type w;
      r    = $urandom_range(0, 9);
      xmax = (tracker.img_width > 6'd32) ? 31 : int'(tracker.img_width) - 1;
      ymax = (tracker.img_height > 6'd32) ? 31 : int'(tracker.img_height) - 1;
      if (r < 7 && xmax >= 0 && ymax >= 0) begin
         read_pixel(5'($urandom_range(0, xmax)), 5'($urandom_range(0, ymax)));
      end else if (r < 8) begin
         read_pixel(5'($urandom), 5'($urandom));
      end else begin
         w = random_word();
         send_word(w);
      end
   endtask

   initial begin
      int phase;
      int quota;
      logic [2:0] code;
      logic [5:0] width;
      logic [5:0] height;
      tracker = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset setting, 8 bpp 32 x 32: field extremes and dropped loads
      send_load(MODE_PALETTE, 12'd0, 8'h00, 24'h000000);
      send_load(MODE_PALETTE, 12'd255, 8'hff, 24'hffffff);
      send_load(MODE_PALETTE, 12'd256, 8'hff, 24'hffffff);   // past the palette, dropped
      send_load(MODE_COLOUR, 12'd992, 8'h00, 24'h0);          // top-left pixel, index 0
      send_load(MODE_COLOUR, 12'd1023, 8'hff, 24'h0);         // top-right pixel, index 255
      send_load(MODE_MASK, 12'd0, 8'h00, 24'h0);
      send_load(MODE_MASK, 12'd124, 8'h80, 24'h0);            // clears alpha at top-left
      send_load(MODE_MASK, 12'd128, 8'hff, 24'h0);            // past the mask store, dropped
      send_load(MODE_MASK, 12'hfff, 8'hff, 24'h0);
      read_pixel(5'd0, 5'd0);
      read_pixel(5'd31, 5'd0);
      read_pixel(5'd0, 5'd31);

      // x555 pixels on a single row, mask covers all eight columns
      set_config(DEPTH_16BPP, 6'd8, 6'd1);
      read_pixel(5'd7, 5'd0);
      read_pixel(5'd8, 5'd0);
      read_pixel(5'd0, 5'd1);

      // bgra pixels at the far corners
      set_config(DEPTH_32BPP, 6'd32, 6'd32);
      read_pixel(5'd31, 5'd31);
      read_pixel(5'd0, 5'd0);

      // depth codes with no format give black, transparent
      set_config(DEPTH_UNUSED_6, 6'd16, 6'd16);
      read_pixel(5'd3, 5'd3);
      set_config(DEPTH_UNUSED_7, 6'd16, 6'd16);
      read_pixel(5'd12, 5'd5);

      // zero width, then zero height: nothing is inside the image
      set_config(DEPTH_8BPP, 6'd0, 6'd32);
      read_pixel(5'd0, 5'd0);
      set_config(DEPTH_8BPP, 6'd32, 6'd0);
      read_pixel(5'd5, 5'd0);

      // oversize image, top rows map past the end of the stores
      set_config(DEPTH_32BPP, 6'd63, 6'd63);
      read_pixel(5'd31, 5'd0);
      read_pixel(5'd0, 5'd31);

      // smallest image, 1 bpp
      set_config(DEPTH_1BPP, 6'd1, 6'd1);
      read_pixel(5'd0, 5'd0);
      read_pixel(5'd1, 5'd0);

      // random settings, a phase of words each
      phase = 0;
      while (words < ITEMS) begin
         code   = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
         width  = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(1, 32));
         height = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(1, 32));
         if (phase == 0) begin
            width  = 6'd32;
            height = 6'd32;
         end
         if (words >= ITEMS - QUIET_ITEMS)
            idle_on = 1'b0;
         // the closing stretch keeps its setting so the sender never pauses
         if (idle_on)
            set_config(code, width, height);
         // long back-pressure while the sender keeps going
         if (phase == 2)
            hold_rsp = 1'b1;
         quota = words + PHASE_ITEMS;
         while (words < quota && words < ITEMS)
            random_item();
         phase++;
      end

      idle_on = 1'b0;
      drain();
      if (tracker.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
